// ===== design/swbg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swbg_pkg
// Shared types, constants and helpers for the boundary ghost state pipeline.
// ----------------------------------------------------------------------------
package swbg_pkg;

	// boundary type codes
	localparam logic [3:0] OP_INNER      = 4'd0;
	localparam logic [3:0] OP_SLIP       = 4'd1;
	localparam logic [3:0] OP_NOSLIP     = 4'd2;
	localparam logic [3:0] OP_ZEROGRAD   = 4'd3;
	localparam logic [3:0] OP_CLAMPED    = 4'd4;
	localparam logic [3:0] OP_CLAMPDEPTH = 4'd5;
	localparam logic [3:0] OP_CLAMPVEL   = 4'd6;
	localparam logic [3:0] OP_FLATHER    = 4'd7;

	// gravity register, q16.16 (9.81 after reset)
	localparam int unsigned GRAV_W = 31;
	localparam logic [GRAV_W-1:0] GRAVITY_RESET = 31'd642908;

	// square root unit: radicand is gravity times a non-negative depth
	localparam int unsigned RAD_W  = 62;
	localparam int unsigned ROOT_W = 31;

	// flather normal flux limit, q16.16 units
	localparam logic signed [49:0] QN_LIMIT = 50'sd70368744177664;

	// state carried alongside the square root
	typedef struct packed {
		logic               status;
		logic               slip;
		logic               flather;
		logic [31:0]        gd;
		logic [31:0]        gx;
		logic [31:0]        gy;
		logic signed [34:0] qn;
		logic signed [34:0] qv;
		logic signed [32:0] dh;
		logic signed [16:0] nx;
		logic signed [16:0] ny;
	} pl_t;

	// saturate to the signed 32-bit range
	function automatic logic [31:0] sat32(input logic signed [65:0] x);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = 66'sd2147483647;
		lo = -66'sd2147483648;
		if (x > hi) begin
			return 32'h7fff_ffff;
		end else if (x < lo) begin
			return 32'h8000_0000;
		end
		return x[31:0];
	endfunction

endpackage

// ===== design/swbg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swbg_front
// Decodes the boundary type, forms the simple ghost states, the rotation
// products, the root radicand, and the rounded normal and tangential flux.
// ----------------------------------------------------------------------------
module swbg_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_i,
	input  logic [3:0]                    op_i,
	input  logic [327:0]                  data_i,
	input  logic [swbg_pkg::GRAV_W-1:0]   gravity,
	output logic                          vld_o,
	output logic [swbg_pkg::RAD_W-1:0]    rad_o,
	output swbg_pkg::pl_t                 pl_o
);

	localparam int unsigned GRAV_W_LOC = swbg_pkg::GRAV_W;

	logic signed [31:0] h, qx, qy, hn, qxn, qyn, he, qxe, qye;
	logic signed [16:0] nx, ny;
	logic signed [31:0] src_x, src_y;
	logic [GRAV_W_LOC-1:0] hpos;
	logic signed [33:0] cl_d, cl_x, cl_y;
	swbg_pkg::pl_t pl_d;

	// stage 1 registers
	logic                          vld_s1;
	logic signed [48:0]            p_xn_s1, p_yn_s1, p_yx_s1, p_xy_s1;
	logic [swbg_pkg::RAD_W-1:0]    rad_s1;
	swbg_pkg::pl_t                 pl_s1;

	// stage 2 sums
	logic signed [49:0] sum_n, sum_v;
	swbg_pkg::pl_t      pl_n;

	// unpack the transfer
	assign h   = data_i[31:0];
	assign qx  = data_i[63:32];
	assign qy  = data_i[95:64];
	assign hn  = data_i[127:96];
	assign qxn = data_i[159:128];
	assign qyn = data_i[191:160];
	assign he  = data_i[223:192];
	assign qxe = data_i[255:224];
	assign qye = data_i[287:256];
	assign nx  = data_i[304:288];
	assign ny  = data_i[321:305];

	// flather rotates the external flux, slip the inner one
	assign src_x = (op_i == swbg_pkg::OP_FLATHER) ? qxe : qx;
	assign src_y = (op_i == swbg_pkg::OP_FLATHER) ? qye : qy;
	assign hpos  = h[31] ? '0 : h[30:0];

	assign cl_d = 34'(he) + 34'(he) - 34'(h);
	assign cl_x = 34'(qxe) + 34'(qxe) - 34'(qx);
	assign cl_y = 34'(qye) + 34'(qye) - 34'(qy);

	// ghost state for the types that need no rotation
	always_comb begin
		pl_d         = '0;
		pl_d.dh      = 33'(he) - 33'(h);
		pl_d.nx      = nx;
		pl_d.ny      = ny;
		unique case (op_i)
			swbg_pkg::OP_INNER: begin
				pl_d.gd = hn;
				pl_d.gx = qxn;
				pl_d.gy = qyn;
			end
			swbg_pkg::OP_SLIP: begin
				pl_d.slip = 1'b1;
				pl_d.gd   = h;
			end
			swbg_pkg::OP_NOSLIP: begin
				pl_d.gd = h;
				pl_d.gx = swbg_pkg::sat32(-66'(qx));
				pl_d.gy = swbg_pkg::sat32(-66'(qy));
			end
			swbg_pkg::OP_ZEROGRAD: begin
				pl_d.gd = h;
				pl_d.gx = qx;
				pl_d.gy = qy;
			end
			swbg_pkg::OP_CLAMPED: begin
				pl_d.gd = swbg_pkg::sat32(66'(cl_d));
				pl_d.gx = swbg_pkg::sat32(66'(cl_x));
				pl_d.gy = swbg_pkg::sat32(66'(cl_y));
			end
			swbg_pkg::OP_CLAMPDEPTH: begin
				pl_d.gd = he;
				pl_d.gx = qx;
				pl_d.gy = qy;
			end
			swbg_pkg::OP_CLAMPVEL: begin
				pl_d.gd = h;
				pl_d.gx = qxe;
				pl_d.gy = qye;
			end
			swbg_pkg::OP_FLATHER: begin
				pl_d.flather = 1'b1;
				pl_d.gd      = h;
			end
			default: begin
				pl_d.status = 1'b1;
			end
		endcase
	end

	// stage 1: products and radicand
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_xn_s1 <= 49'(src_x) * 49'(nx);
			p_yn_s1 <= 49'(src_y) * 49'(ny);
			p_yx_s1 <= 49'(src_y) * 49'(nx);
			p_xy_s1 <= 49'(src_x) * 49'(ny);
			rad_s1  <= swbg_pkg::RAD_W'(gravity) * swbg_pkg::RAD_W'(hpos);
			pl_s1   <= pl_d;
		end
	end

	// stage 2: rounded normal and tangential flux
	assign sum_n = 50'(p_xn_s1) + 50'(p_yn_s1) + 50'sd16384;
	assign sum_v = 50'(p_yx_s1) - 50'(p_xy_s1) + 50'sd16384;

	always_comb begin
		pl_n    = pl_s1;
		pl_n.qn = sum_n[49:15];
		pl_n.qv = sum_v[49:15];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_o <= rad_s1;
			pl_o  <= pl_n;
		end
	end

endmodule

// ===== design/swbg_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swbg_sqrt
// Pipelined integer square root, one root bit per stage, with the item
// state traveling alongside.
// ----------------------------------------------------------------------------
module swbg_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_i,
	input  logic [swbg_pkg::RAD_W-1:0]    rad_i,
	input  swbg_pkg::pl_t                 pl_i,
	output logic                          vld_o,
	output logic [swbg_pkg::ROOT_W-1:0]   root_o,
	output swbg_pkg::pl_t                 pl_o
);

	localparam int unsigned RW = swbg_pkg::RAD_W;
	localparam int unsigned QW = swbg_pkg::ROOT_W;

	logic [RW-1:0]  rem_s  [QW-1];
	logic [QW-1:0]  root_s [QW];
	swbg_pkg::pl_t  pl_s   [QW];
	logic           vld_s  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_bit
		localparam int unsigned B = QW - 1 - k;
		logic [RW-1:0]  rem_in;
		logic [QW-1:0]  root_in;
		swbg_pkg::pl_t  pl_in;
		logic           vld_in;
		logic [RW:0]    trial;
		logic           take;

		if (k == 0) begin : g_first
			assign rem_in  = rad_i;
			assign root_in = '0;
			assign pl_in   = pl_i;
			assign vld_in  = vld_i;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign pl_in   = pl_s[k-1];
			assign vld_in  = vld_s[k-1];
		end

		// trial subtrahend (2*root + bit) * bit
		assign trial = ((RW+1)'(root_in) << (B + 1)) | ((RW+1)'(1) << (2 * B));
		assign take  = ({1'b0, rem_in} >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k] <= take ? (root_in | (QW'(1) << B)) : root_in;
				pl_s[k]   <= pl_in;
			end
		end

		// the last stage needs no remainder
		if (k < QW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= take ? (rem_in - trial[RW-1:0]) : rem_in;
				end
			end
		end
	end

	assign vld_o  = vld_s[QW-1];
	assign root_o = root_s[QW-1];
	assign pl_o   = pl_s[QW-1];

endmodule

// ===== design/swbg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swbg_back
// Flather correction term, rotation back to x/y, rounding, saturation and
// the output register.
// ----------------------------------------------------------------------------
module swbg_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_i,
	input  logic [swbg_pkg::ROOT_W-1:0]   root_i,
	input  swbg_pkg::pl_t                 pl_i,
	output logic                          vld_o,
	output logic [95:0]                   data_o,
	output logic                          status_o
);

	// stage 1: c times depth difference
	logic                  vld_s1;
	logic signed [64:0]    tp_s1;
	swbg_pkg::pl_t         pl_s1;

	// stage 2: corrected normal flux
	logic signed [65:0]    tr;
	logic signed [49:0]    term, qf;
	logic signed [47:0]    a_d;
	logic                  vld_s2;
	logic signed [47:0]    a_s2;
	swbg_pkg::pl_t         pl_s2;

	// stage 3: rotation products
	logic                  vld_s3;
	logic signed [64:0]    pa_nx_s3, pa_ny_s3, pb_nx_s3, pb_ny_s3;
	swbg_pkg::pl_t         pl_s3;

	// stage 4: sums and output
	logic signed [65:0]    sx, sy;
	logic                  rot;
	logic [31:0]           gd_s4, gx_s4, gy_s4;
	logic                  st_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_o  <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_o  <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tp_s1 <= 65'($signed({1'b0, root_i})) * 65'($signed(pl_i.dh));
			pl_s1 <= pl_i;
		end
	end

	// round the term, subtract, clamp; slip reflects the normal flux
	assign tr   = 66'(tp_s1) + 66'sd32768;
	assign term = tr[65:16];
	assign qf   = 50'($signed(pl_s1.qn)) - term;

	always_comb begin
		if (pl_s1.flather) begin
			if (qf > swbg_pkg::QN_LIMIT) begin
				a_d = swbg_pkg::QN_LIMIT[47:0];
			end else if (qf < -swbg_pkg::QN_LIMIT) begin
				a_d = 48'(-swbg_pkg::QN_LIMIT);
			end else begin
				a_d = qf[47:0];
			end
		end else begin
			a_d = -48'($signed(pl_s1.qn));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2  <= a_d;
			pl_s2 <= pl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_nx_s3 <= 65'(a_s2) * 65'($signed(pl_s2.nx));
			pa_ny_s3 <= 65'(a_s2) * 65'($signed(pl_s2.ny));
			pb_nx_s3 <= 65'($signed(pl_s2.qv)) * 65'($signed(pl_s2.nx));
			pb_ny_s3 <= 65'($signed(pl_s2.qv)) * 65'($signed(pl_s2.ny));
			pl_s3    <= pl_s2;
		end
	end

	// gx = a*nx - qv*ny, gy = a*ny + qv*nx, rounded half up
	assign sx  = 66'(pa_nx_s3) - 66'(pb_ny_s3) + 66'sd16384;
	assign sy  = 66'(pa_ny_s3) + 66'(pb_nx_s3) + 66'sd16384;
	assign rot = pl_s3.slip | pl_s3.flather;

	always_ff @(posedge clk) begin
		if (en) begin
			gd_s4 <= pl_s3.gd;
			gx_s4 <= rot ? swbg_pkg::sat32(sx >>> 15) : pl_s3.gx;
			gy_s4 <= rot ? swbg_pkg::sat32(sy >>> 15) : pl_s3.gy;
			st_s4 <= pl_s3.status;
		end
	end

	assign data_o   = {gy_s4, gx_s4, gd_s4};
	assign status_o = st_s4;

endmodule

// ===== design/shallow_water_boundary_ghost_state.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shallow_water_boundary_ghost_state
// Ghost depth and fluxes at one boundary node for eight boundary types.
// ----------------------------------------------------------------------------
// throughput: one node per cycle while the output is not stalled; the depth
// is set by the 31-stage square root
// a stall at the output holds every stage in place
// reset: all valid bits clear, gravity returns to 9.81 (q16.16)
module shallow_water_boundary_ghost_state (
	input  logic          clk,
	input  logic          arst_n,
	// configuration: gravity, q16.16
	input  logic          cfg_we,
	input  logic [30:0]   cfg_wdata,
	// input stream
	input  logic          s_tvalid,
	output logic          s_tready,
	// inner_depth, inner_qx, inner_qy, neighbor_depth, neighbor_qx, neighbor_qy,
	// ext_depth, ext_qx, ext_qy, normal_x, normal_y, zero fill
	input  logic [327:0]  s_tdata,
	// operation
	input  logic [3:0]    s_tuser,
	// output stream
	output logic          m_tvalid,
	input  logic          m_tready,
	// ghost_depth, ghost_qx, ghost_qy
	output logic [95:0]   m_tdata,
	// status
	output logic          m_tuser
);

	logic                               en;
	logic [swbg_pkg::GRAV_W-1:0]        gravity_q;
	logic                               fr_vld;
	logic [swbg_pkg::RAD_W-1:0]         fr_rad;
	swbg_pkg::pl_t                      fr_pl;
	logic                               sq_vld;
	logic [swbg_pkg::ROOT_W-1:0]        sq_root;
	swbg_pkg::pl_t                      sq_pl;

	// whole pipeline advances unless a finished result is held
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// gravity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= swbg_pkg::GRAVITY_RESET;
		end else if (cfg_we) begin
			gravity_q <= cfg_wdata;
		end
	end

	swbg_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_i   (s_tvalid),
		.op_i    (s_tuser),
		.data_i  (s_tdata),
		.gravity (gravity_q),
		.vld_o   (fr_vld),
		.rad_o   (fr_rad),
		.pl_o    (fr_pl)
	);

	swbg_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (fr_vld),
		.rad_i  (fr_rad),
		.pl_i   (fr_pl),
		.vld_o  (sq_vld),
		.root_o (sq_root),
		.pl_o   (sq_pl)
	);

	swbg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_i    (sq_vld),
		.root_i   (sq_root),
		.pl_i     (sq_pl),
		.vld_o    (m_tvalid),
		.data_o   (m_tdata),
		.status_o (m_tuser)
	);

	// unknown type gives all-zero ghost state
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("status set with nonzero ghost state");

	// a held result blocks new input
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	// type flags stay exclusive through the root pipeline
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		sq_vld |-> $onehot0({sq_pl.status, sq_pl.slip, sq_pl.flather}))
		else $error("boundary type flags overlap");

	// gravity write takes effect
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> gravity_q == $past(cfg_wdata))
		else $error("gravity write lost");

endmodule

// ===== dv/shallow_water_boundary_ghost_state_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shallow_water_boundary_ghost_state_test
// Self-checking bench for the boundary ghost state pipeline. It streams
// directed and random boundary nodes and predicts the ghost depth and fluxes
// of every node, including the slip rotation and the Flather root. Gravity
// is swept through several values, and both stream sides stall at random.
// ----------------------------------------------------------------------------
module shallow_water_boundary_ghost_state_test;

	typedef struct {
		logic [3:0]         operation;
		logic signed [31:0] h, qx, qy, hn, qxn, qyn, he, qxe, qye;
		logic signed [16:0] nx, ny;
	} node_t;

	typedef struct {
		logic [31:0] gd, gx, gy;
		logic        status;
	} ghost_t;

	typedef struct {
		node_t  nd;
		logic   typed;
		ghost_t res;
	} dir_row_t;

	logic          clk;
	logic          arst_n;
	logic          cfg_we;
	logic [30:0]   cfg_wdata;
	logic          s_tvalid;
	logic          s_tready;
	logic [327:0]  s_tdata;
	logic [3:0]    s_tuser;
	logic          m_tvalid;
	logic          m_tready;
	logic [95:0]   m_tdata;
	logic          m_tuser;

	// predictor copy of the gravity register
	logic [30:0]   grav_model;
	ghost_t        ghost_q[$];
	dir_row_t      dir_rows[$];
	int            errors;
	int            nodes_sent;
	int            ghosts_seen;
	int            idle_cycles;
	int            unknown_sent;
	int            flather_sent;
	int            grav_writes;
	bit            calm;
	bit            started;

	shallow_water_boundary_ghost_state dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// round half up, then floor shift
	function automatic longint round_shift(longint x, int s);
		return (x + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic logic [31:0] clip32(longint x);
		if (x > 64'sd2147483647) begin
			return 32'h7fff_ffff;
		end else if (x < -64'sd2147483648) begin
			return 32'h8000_0000;
		end
		return x[31:0];
	endfunction

	// integer square root, bit by bit
	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// ghost state of one boundary node
	function automatic ghost_t ghost_of(node_t n, logic [30:0] g);
		longint h, qx, qy, hn, qxn, qyn, he, qxe, qye, nx, ny;
		longint gd, gx, gy, qn, qv, c, term, lim;
		longint unsigned rad;
		ghost_t r;
		h = n.h; qx = n.qx; qy = n.qy;
		hn = n.hn; qxn = n.qxn; qyn = n.qyn;
		he = n.he; qxe = n.qxe; qye = n.qye;
		nx = n.nx; ny = n.ny;
		gd = 0; gx = 0; gy = 0;
		lim = longint'(1) << 46;
		r.status = 1'b0;
		case (n.operation)
			swbg_pkg::OP_INNER: begin
				gd = hn; gx = qxn; gy = qyn;
			end
			swbg_pkg::OP_SLIP: begin
				qn = round_shift(qx * nx + qy * ny, 15);
				qv = round_shift(qy * nx - qx * ny, 15);
				gd = h;
				gx = round_shift(-qn * nx - qv * ny, 15);
				gy = round_shift(-qn * ny + qv * nx, 15);
			end
			swbg_pkg::OP_NOSLIP: begin
				gd = h; gx = -qx; gy = -qy;
			end
			swbg_pkg::OP_ZEROGRAD: begin
				gd = h; gx = qx; gy = qy;
			end
			swbg_pkg::OP_CLAMPED: begin
				gd = 2 * he - h; gx = 2 * qxe - qx; gy = 2 * qye - qy;
			end
			swbg_pkg::OP_CLAMPDEPTH: begin
				gd = he; gx = qx; gy = qy;
			end
			swbg_pkg::OP_CLAMPVEL: begin
				gd = h; gx = qxe; gy = qye;
			end
			swbg_pkg::OP_FLATHER: begin
				qn = round_shift(qxe * nx + qye * ny, 15);
				qv = round_shift(qye * nx - qxe * ny, 15);
				rad = longint'(g) * ((h > 0) ? h : 0);
				c = int_root(rad);
				term = round_shift(c * (he - h), 16);
				qn = qn - term;
				if (qn > lim) qn = lim;
				if (qn < -lim) qn = -lim;
				gd = h;
				gx = round_shift(qn * nx - qv * ny, 15);
				gy = round_shift(qn * ny + qv * nx, 15);
			end
			default: begin
				r.status = 1'b1;
			end
		endcase
		r.gd = clip32(gd);
		r.gx = clip32(gx);
		r.gy = clip32(gy);
		return r;
	endfunction

	function automatic node_t mk_node(logic [3:0] op, logic signed [31:0] h, qx, qy,
			hn, qxn, qyn, he, qxe, qye, logic signed [16:0] nx, ny);
		node_t n;
		n.operation = op;
		n.h = h; n.qx = qx; n.qy = qy;
		n.hn = hn; n.qxn = qxn; n.qyn = qyn;
		n.he = he; n.qxe = qxe; n.qye = qye;
		n.nx = nx; n.ny = ny;
		return n;
	endfunction

	function automatic ghost_t mk_ghost(logic [31:0] gd, gx, gy, logic st);
		ghost_t r;
		r.gd = gd; r.gx = gx; r.gy = gy; r.status = st;
		return r;
	endfunction

	// mostly ordinary values, with extremes and small ones mixed in
	function automatic logic signed [31:0] rand_q(bit positive);
		logic signed [31:0] v;
		case ($urandom_range(0, 7))
			0: v = 32'sh7fff_ffff;
			1: v = 32'sh8000_0000;
			2: v = 0;
			3: v = $signed($urandom_range(0, 2000)) - 1000;
			4, 5: v = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
			default: v = $urandom;
		endcase
		if (positive && v < 0 && $urandom_range(0, 3) != 0) v = -(v + 1);
		return v;
	endfunction

	function automatic logic signed [16:0] rand_normal();
		case ($urandom_range(0, 5))
			0: return 17'sd32768;
			1: return -17'sd32768;
			2: return 17'sd0;
			3: return ($urandom_range(0, 1) != 0) ? 17'sd23170 : -17'sd23170;
			default: return 17'($signed($urandom_range(0, 65536)) - 32768);
		endcase
	endfunction

	function automatic node_t rand_node();
		node_t n;
		bit wet;
		n.operation = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
		                                          : 4'($urandom_range(0, 7));
		wet = (n.operation == swbg_pkg::OP_FLATHER);
		n.h = rand_q(wet); n.qx = rand_q(0); n.qy = rand_q(0);
		n.hn = rand_q(1); n.qxn = rand_q(0); n.qyn = rand_q(0);
		n.he = rand_q(wet); n.qxe = rand_q(0); n.qye = rand_q(0);
		n.nx = rand_normal(); n.ny = rand_normal();
		return n;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s at ghost %0d: got %h, want %h", what, ghosts_seen, got, want);
		errors++;
	endtask

	// offer one node and wait for its transfer
	task automatic send_node(node_t n, logic typed, ghost_t want);
		int gap;
		bit ok;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= n.operation;
		s_tdata  <= {6'd0, n.ny, n.nx, n.qye, n.qxe, n.he, n.qyn, n.qxn, n.hn,
		             n.qy, n.qx, n.h};
		do begin
			@(negedge clk);
			ok = s_tready;
			if (ok) begin
				ghost_q.push_back(typed ? want : ghost_of(n, grav_model));
				nodes_sent++;
				if (n.operation > swbg_pkg::OP_FLATHER) unknown_sent++;
				if (n.operation == swbg_pkg::OP_FLATHER) flather_sent++;
			end
			@(posedge clk);
		end while (!ok);
	endtask

	task automatic drain_and_settle();
		s_tvalid <= 1'b0;
		while (ghost_q.size() != 0) @(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	task automatic write_gravity(logic [30:0] g);
		cfg_we    <= 1'b1;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_we    <= 1'b0;
		grav_model = g;
		grav_writes++;
	endtask

	// result check, sampled away from the rising edge
	always @(negedge clk) begin
		ghost_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (ghost_q.size() == 0) begin
				$display("unexpected ghost state %h", m_tdata);
				errors++;
			end else begin
				want = ghost_q.pop_front();
				if (m_tdata[31:0] !== want.gd) report("depth", m_tdata[31:0], want.gd);
				if (m_tdata[63:32] !== want.gx) report("qx", m_tdata[63:32], want.gx);
				if (m_tdata[95:64] !== want.gy) report("qy", m_tdata[95:64], want.gy);
				if (m_tuser !== want.status)
					report("status", 32'(m_tuser), 32'(want.status));
			end
			ghosts_seen++;
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(negedge clk) begin
		if (started) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= 5000) begin
					$display("[shallow_water_boundary_ghost_state] ERROR");
					$finish;
				end
			end
		end
	end

	// receiver: random stalls, one long hold-off to back up the pipeline
	initial begin
		bit held;
		int stall;
		bit ok;
		held = 0;
		m_tready = 1'b0;
		wait (started);
		@(posedge clk);
		forever begin
			if (!held && nodes_sent > 400) begin
				held = 1;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				stall = calm ? 0 : $urandom_range(0, 7);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do begin
				@(negedge clk);
				ok = m_tvalid;
				@(posedge clk);
			end while (!ok);
		end
	end

	initial begin
		ghost_t none;
		logic [30:0] grav_sweep[5];
		int k;
		none = mk_ghost(0, 0, 0, 0);
		errors = 0; nodes_sent = 0; ghosts_seen = 0; idle_cycles = 0;
		unknown_sent = 0; flather_sent = 0; grav_writes = 0;
		calm = 0; started = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		grav_model = swbg_pkg::GRAVITY_RESET;

		// directed nodes: extremes, every boundary type, special cases
		dir_rows.push_back('{mk_node(swbg_pkg::OP_INNER, 1, 2, 3, 32'sh0001_0000, -5, 7,
			0, 0, 0, 32768, 0), 1, mk_ghost(32'h0001_0000, 32'hffff_fffb, 7, 0)});
		dir_rows.push_back('{mk_node(4'd8, 5, 5, 5, 5, 5, 5, 5, 5, 5, 1, 1), 1,
			mk_ghost(0, 0, 0, 1)});
		dir_rows.push_back('{mk_node(4'd15, -1, -1, -1, -1, -1, -1, -1, -1, -1,
			-32768, -32768), 1, mk_ghost(0, 0, 0, 1)});
		dir_rows.push_back('{mk_node(swbg_pkg::OP_NOSLIP, 9, 32'sh8000_0000,
			32'sh7fff_ffff, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			mk_ghost(9, 32'h7fff_ffff, 32'h8000_0001, 0)});
		dir_rows.push_back('{mk_node(swbg_pkg::OP_CLAMPED, 32'sh8000_0000,
			32'sh7fff_ffff, 0, 0, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 3, 0, 0), 1,
			mk_ghost(32'h7fff_ffff, 32'h8000_0000, 6, 0)});
		dir_rows.push_back('{mk_node(swbg_pkg::OP_ZEROGRAD, 32'sh7fff_ffff,
			32'sh8000_0000, 4, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			mk_ghost(32'h7fff_ffff, 32'h8000_0000, 4, 0)});
		dir_rows.push_back('{mk_node(swbg_pkg::OP_CLAMPDEPTH, 1, 2, 3, 0, 0, 0,
			32'sh8000_0000, 8, 9, 0, 0), 1, mk_ghost(32'h8000_0000, 2, 3, 0)});
		dir_rows.push_back('{mk_node(swbg_pkg::OP_CLAMPVEL, 1, 2, 3, 0, 0, 0, 7,
			32'sh7fff_ffff, -4, 0, 0), 1, mk_ghost(1, 32'h7fff_ffff, 32'hffff_fffc, 0)});
		dir_rows.push_back('{mk_node(swbg_pkg::OP_SLIP, 100, 32'sh0001_0000,
			32'sh0002_0000, 0, 0, 0, 0, 0, 0, 32768, 0), 0, none});
		dir_rows.push_back('{mk_node(swbg_pkg::OP_SLIP, 100, 32'sh7fff_ffff,
			32'sh8000_0000, 0, 0, 0, 0, 0, 0, -32768, -32768), 0, none});
		dir_rows.push_back('{mk_node(swbg_pkg::OP_SLIP, 5, 12345, -6789, 0, 0, 0, 0, 0,
			0, 23170, -23170), 0, none});
		// negative depth under the root
		dir_rows.push_back('{mk_node(swbg_pkg::OP_FLATHER, -32'sh0001_0000, 0, 0, 0, 0,
			0, 32'sh0003_0000, 32'sh0001_0000, 0, 32768, 0), 0, none});
		dir_rows.push_back('{mk_node(swbg_pkg::OP_FLATHER, 32'sh0002_0000, 0, 0, 0, 0,
			0, 32'sh0003_0000, 32'sh0001_0000, 32'sh0000_8000, 0, 32768), 0, none});
		// extreme depths and fluxes, well inside the normal flux limit
		dir_rows.push_back('{mk_node(swbg_pkg::OP_FLATHER, 32'sh7fff_ffff, 0, 0, 0, 0,
			0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, -32768, 32768), 0,
			none});
		dir_rows.push_back('{mk_node(swbg_pkg::OP_FLATHER, 32'sh0000_0001,
			32'sh8000_0000, 0, 0, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000,
			32'sh8000_0000, 32768, 32768), 0, none});
		dir_rows.push_back('{mk_node(swbg_pkg::OP_INNER, 0, 0, 0, 32'sh8000_0000,
			32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 0, 0, 0), 1,
			mk_ghost(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0)});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		started = 1;

		foreach (dir_rows[i]) send_node(dir_rows[i].nd, dir_rows[i].typed, dir_rows[i].res);

		// random nodes under a sweep of gravity values
		grav_sweep[0] = 31'h7fff_ffff;
		grav_sweep[1] = 0;
		grav_sweep[2] = 31'($urandom);
		grav_sweep[3] = 1;
		grav_sweep[4] = swbg_pkg::GRAVITY_RESET;
		for (int p = 0; p < 5; p++) begin
			drain_and_settle();
			write_gravity(grav_sweep[p]);
			for (k = 0; k < 150; k++) begin
				if (k % 40 == 0) calm = ($urandom_range(0, 2) == 0);
				if (p == 1 && k == 70) begin
					s_tvalid <= 1'b0;
					while (ghost_q.size() != 0) @(posedge clk);
				end
				send_node(rand_node(), 0, none);
			end
		end
		s_tvalid <= 1'b0;
		while (ghost_q.size() != 0) @(posedge clk);
		repeat (45) @(posedge clk);

		$display("covered %0d nodes (%0d flather, %0d unknown type) over %0d gravity settings",
			nodes_sent, flather_sent, unknown_sent, grav_writes + 1);
		$display("checked %0d ghost states, %0d mismatches", ghosts_seen, errors);
		if (errors == 0) begin
			$display("[shallow_water_boundary_ghost_state] OK");
		end else begin
			$display("[shallow_water_boundary_ghost_state] ERROR");
		end
		$finish;
	end

endmodule
